// ----- hdl/phsv_pkg.sv -----
package phsv_pkg;

    typedef struct packed {
        logic [7:0] chan_a;
        logic [7:0] chan_b;
        logic [7:0] chan_c;
    } pix_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [8:0] hue;
        logic [6:0] saturation;
        logic [6:0] brightness;
    } hsv_t;

    // which channel holds the maximum
    localparam logic [1:0] SEC_RED   = 2'd0;
    localparam logic [1:0] SEC_GREEN = 2'd1;
    localparam logic [1:0] SEC_BLUE  = 2'd2;

    localparam int QUO_BITS = 7;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } rgb_t;

    typedef struct packed {
        logic [7:0]          red;
        logic [7:0]          green;
        logic [7:0]          blue;
        logic [6:0]          brightness;
        logic [1:0]          sector;
        logic                flat;
        logic                h_neg;
        logic [14:0]         s_rem;
        logic [7:0]          s_div;
        logic [QUO_BITS-1:0] s_quo;
        logic [13:0]         h_rem;
        logic [7:0]          h_div;
        logic [QUO_BITS-1:0] h_quo;
    } cell_t;

endpackage

// ----- hdl/phsv_front.sv -----
module phsv_front
    import phsv_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic wr_en,
    input  logic wr_data,
    input  logic in_valid,
    input  pix_t in_pix,
    output logic ready,
    output logic out_valid,
    output rgb_t out_rgb,
    input  logic ready_dn
);

    logic yuv_reg;

    logic v1_reg, v2_reg, v3_reg;
    logic ready1, ready2, ready3;

    // stage 1: hundredths numerators
    logic signed [16:0] a17, cu17, cv17;
    logic signed [16:0] num_r_next, num_g_next, num_b_next;
    logic signed [16:0] num_r_reg, num_g_reg, num_b_reg;
    pix_t               pix1_reg;

    // stage 2: divide by 100 through reciprocal
    logic [32:0] prod_r, prod_g, prod_b;
    logic [8:0]  q_r_next, q_g_next, q_b_next;
    logic [8:0]  q_r_reg, q_g_reg, q_b_reg;
    logic        n_r_reg, n_g_reg, n_b_reg;
    pix_t        pix2_reg;

    // stage 3: clamp and select
    rgb_t rgb_next, rgb_reg;

    function automatic logic [7:0] clamp_q(input logic neg, input logic [8:0] q);
        logic [7:0] res;
        if (neg)
            res = 8'd0;
        else if (q > 9'd255)
            res = 8'd255;
        else
            res = q[7:0];
        return res;
    endfunction

    assign ready3 = !v3_reg || ready_dn;
    assign ready2 = !v2_reg || ready3;
    assign ready1 = !v1_reg || ready2;
    assign ready  = ready1;

    assign a17  = $signed({9'd0, in_pix.chan_a});
    assign cu17 = $signed({9'd0, in_pix.chan_b}) - 17'sd128;
    assign cv17 = $signed({9'd0, in_pix.chan_c}) - 17'sd128;

    assign num_r_next = 17'sd100 * a17 + 17'sd137 * cv17;
    assign num_g_next = 17'sd100 * a17 - 17'sd70 * cv17 - 17'sd34 * cu17;
    assign num_b_next = 17'sd100 * a17 + 17'sd173 * cu17;

    // floor(n/100) == (n*83887)>>23 for n below 91180
    assign prod_r = {17'd0, num_r_reg[15:0]} * 33'd83887;
    assign prod_g = {17'd0, num_g_reg[15:0]} * 33'd83887;
    assign prod_b = {17'd0, num_b_reg[15:0]} * 33'd83887;
    assign q_r_next = prod_r[31:23];
    assign q_g_next = prod_g[31:23];
    assign q_b_next = prod_b[31:23];

    always_comb
    begin
        if (yuv_reg)
        begin
            rgb_next.red   = clamp_q(n_r_reg, q_r_reg);
            rgb_next.green = clamp_q(n_g_reg, q_g_reg);
            rgb_next.blue  = clamp_q(n_b_reg, q_b_reg);
        end
        else
        begin
            rgb_next.red   = pix2_reg.chan_a;
            rgb_next.green = pix2_reg.chan_b;
            rgb_next.blue  = pix2_reg.chan_c;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            yuv_reg <= 1'b0;
            v1_reg  <= 1'b0;
            v2_reg  <= 1'b0;
            v3_reg  <= 1'b0;
        end
        else
        begin
            if (wr_en)
                yuv_reg <= wr_data;
            if (ready1)
                v1_reg <= in_valid;
            if (ready2)
                v2_reg <= v1_reg;
            if (ready3)
                v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready1)
        begin
            pix1_reg  <= in_pix;
            num_r_reg <= num_r_next;
            num_g_reg <= num_g_next;
            num_b_reg <= num_b_next;
        end
        if (ready2)
        begin
            pix2_reg <= pix1_reg;
            q_r_reg  <= q_r_next;
            q_g_reg  <= q_g_next;
            q_b_reg  <= q_b_next;
            n_r_reg  <= num_r_reg[16];
            n_g_reg  <= num_g_reg[16];
            n_b_reg  <= num_b_reg[16];
        end
        if (ready3)
            rgb_reg <= rgb_next;
    end

    assign out_valid = v3_reg;
    assign out_rgb   = rgb_reg;

endmodule

// ----- hdl/phsv_prep.sv -----
module phsv_prep
    import phsv_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    input  rgb_t  in_rgb,
    output logic  ready,
    output logic  out_valid,
    output cell_t out_cell,
    input  logic  ready_dn
);

    logic v1_reg, v2_reg;
    logic ready1, ready2;

    // stage 1: max, min, sector and signed hue difference
    logic       r_top, g_top;
    logic [7:0] mx_next, mn_next;
    logic [8:0] diff;
    logic [1:0] sec_next;
    logic [7:0] mag_next;
    rgb_t       rgb1_reg;
    logic [7:0] mx_reg, d_reg, mag_reg;
    logic [1:0] sec_reg;
    logic       neg_reg;

    // stage 2: brightness and divider numerators
    logic [30:0] vprod;
    cell_t       cell_next, cell_reg;

    assign ready2 = !v2_reg || ready_dn;
    assign ready1 = !v1_reg || ready2;
    assign ready  = ready1;

    // ties go to red, then green
    assign r_top = (in_rgb.red >= in_rgb.green) && (in_rgb.red >= in_rgb.blue);
    assign g_top = !r_top && (in_rgb.green >= in_rgb.blue);

    always_comb
    begin
        if (r_top)
        begin
            sec_next = SEC_RED;
            mx_next  = in_rgb.red;
            diff     = {1'b0, in_rgb.green} - {1'b0, in_rgb.blue};
        end
        else if (g_top)
        begin
            sec_next = SEC_GREEN;
            mx_next  = in_rgb.green;
            diff     = {1'b0, in_rgb.blue} - {1'b0, in_rgb.red};
        end
        else
        begin
            sec_next = SEC_BLUE;
            mx_next  = in_rgb.blue;
            diff     = {1'b0, in_rgb.red} - {1'b0, in_rgb.green};
        end
        mn_next = in_rgb.red;
        if (in_rgb.green < mn_next)
            mn_next = in_rgb.green;
        if (in_rgb.blue < mn_next)
            mn_next = in_rgb.blue;
        mag_next = diff[8] ? 8'(-diff) : diff[7:0];
    end

    // floor(mx*100/255) == (mx*6579400)>>24 over the 8-bit range
    assign vprod = {23'd0, mx_reg} * 31'd6579400;

    always_comb
    begin
        cell_next.red        = rgb1_reg.red;
        cell_next.green      = rgb1_reg.green;
        cell_next.blue       = rgb1_reg.blue;
        cell_next.brightness = vprod[30:24];
        cell_next.sector     = sec_reg;
        cell_next.flat       = (d_reg == 8'd0);
        cell_next.h_neg      = neg_reg;
        cell_next.s_rem      = {7'd0, d_reg} * 15'd100;
        cell_next.s_div      = mx_reg;
        cell_next.s_quo      = '0;
        cell_next.h_rem      = {6'd0, mag_reg} * 14'd60;
        cell_next.h_div      = d_reg;
        cell_next.h_quo      = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            if (ready1)
                v1_reg <= in_valid;
            if (ready2)
                v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready1)
        begin
            rgb1_reg <= in_rgb;
            mx_reg   <= mx_next;
            d_reg    <= mx_next - mn_next;
            mag_reg  <= mag_next;
            sec_reg  <= sec_next;
            neg_reg  <= diff[8];
        end
        if (ready2)
            cell_reg <= cell_next;
    end

    assign out_valid = v2_reg;
    assign out_cell  = cell_reg;

endmodule

// ----- hdl/phsv_div_cell.sv -----
module phsv_div_cell
    import phsv_pkg::*;
#(
    parameter int SHIFT = 0
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    input  cell_t in_cell,
    output logic  ready,
    output logic  out_valid,
    output cell_t out_cell,
    input  logic  ready_dn
);

    logic        valid_reg;
    cell_t       cell_next, cell_reg;
    logic [14:0] s_trial;
    logic [13:0] h_trial;

    assign ready = !valid_reg || ready_dn;

    // one restoring step per divider: try divisor shifted to this quotient bit
    assign s_trial = {7'd0, in_cell.s_div} << SHIFT;
    assign h_trial = {6'd0, in_cell.h_div} << SHIFT;

    always_comb
    begin
        cell_next = in_cell;
        if (in_cell.s_rem >= s_trial)
        begin
            cell_next.s_rem        = in_cell.s_rem - s_trial;
            cell_next.s_quo[SHIFT] = 1'b1;
        end
        if (in_cell.h_rem >= h_trial)
        begin
            cell_next.h_rem        = in_cell.h_rem - h_trial;
            cell_next.h_quo[SHIFT] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (ready)
            cell_reg <= cell_next;
    end

    assign out_valid = valid_reg;
    assign out_cell  = cell_reg;

endmodule

// ----- hdl/pixel_to_hsv_percent.sv -----
// Streaming pixel to HSV converter. Accepts one pixel beat per clock while
// pix_stall is low and delivers one result beat per pixel. The front stages
// do the optional YUV to RGB conversion, the prep stages find max/min and set
// up the dividers, the divider chain (one cell per quotient bit, shared by
// the saturation and hue divisions) forms the quotients, and the output
// register holds the result. Every stage holds one beat and moves it on
// whenever the next one is free, so a stall at the output only stops the
// input once all stages are full. The format bit (wr_en/wr_data) selects RGB
// or YUV input and is meant to be changed only while the pipeline is empty.
module pixel_to_hsv_percent
    import phsv_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic wr_en,
    input  logic wr_data,
    input  logic pix_valid,
    output logic pix_stall,
    input  pix_t pix,
    output logic hsv_valid,
    input  logic hsv_stall,
    output hsv_t hsv
);

    localparam int NCELL = QUO_BITS;

    logic front_ready, front_valid;
    rgb_t front_rgb;
    logic prep_ready, prep_valid;

    cell_t chain_cell  [NCELL+1];
    logic  chain_valid [NCELL+1];
    logic  chain_ready [NCELL+1];

    logic       fin_ready;
    logic       hsv_valid_reg;
    hsv_t       hsv_next, hsv_reg;
    logic [8:0] q9;

    phsv_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (wr_en),
        .wr_data   (wr_data),
        .in_valid  (pix_valid),
        .in_pix    (pix),
        .ready     (front_ready),
        .out_valid (front_valid),
        .out_rgb   (front_rgb),
        .ready_dn  (prep_ready)
    );

    phsv_prep u_prep (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (front_valid),
        .in_rgb    (front_rgb),
        .ready     (prep_ready),
        .out_valid (prep_valid),
        .out_cell  (chain_cell[0]),
        .ready_dn  (chain_ready[0])
    );

    assign chain_valid[0] = prep_valid;

    // cells run from the top quotient bit down
    for (genvar i = 0; i < NCELL; i++)
    begin : g_cell
        phsv_div_cell #(
            .SHIFT (NCELL - 1 - i)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (chain_valid[i]),
            .in_cell   (chain_cell[i]),
            .ready     (chain_ready[i]),
            .out_valid (chain_valid[i+1]),
            .out_cell  (chain_cell[i+1]),
            .ready_dn  (chain_ready[i+1])
        );
    end

    assign fin_ready          = !hsv_valid_reg || !hsv_stall;
    assign chain_ready[NCELL] = fin_ready;

    assign q9 = {2'd0, chain_cell[NCELL].h_quo};

    always_comb
    begin
        hsv_next.red        = chain_cell[NCELL].red;
        hsv_next.green      = chain_cell[NCELL].green;
        hsv_next.blue       = chain_cell[NCELL].blue;
        hsv_next.brightness = chain_cell[NCELL].brightness;
        hsv_next.saturation = chain_cell[NCELL].s_quo;
        case (chain_cell[NCELL].sector)
            SEC_RED:   hsv_next.hue = chain_cell[NCELL].h_neg ? 9'd360 - q9 : q9;
            SEC_GREEN: hsv_next.hue = chain_cell[NCELL].h_neg ? 9'd120 - q9 : 9'd120 + q9;
            SEC_BLUE:  hsv_next.hue = chain_cell[NCELL].h_neg ? 9'd240 - q9 : 9'd240 + q9;
            default:   hsv_next.hue = 9'd0;
        endcase
        // grey or black: the hue divisor (max minus min) was zero
        if (chain_cell[NCELL].flat)
        begin
            hsv_next.hue        = 9'd0;
            hsv_next.saturation = 7'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hsv_valid_reg <= 1'b0;
        else if (fin_ready)
            hsv_valid_reg <= chain_valid[NCELL];
    end

    always_ff @(posedge clk)
    begin
        if (fin_ready)
            hsv_reg <= hsv_next;
    end

    assign pix_stall = !front_ready;
    assign hsv_valid = hsv_valid_reg;
    assign hsv       = hsv_reg;

`ifndef SYNTHESIS
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        hsv_valid |-> (hsv.hue <= 9'd360) && (hsv.saturation <= 7'd100)
                      && (hsv.brightness <= 7'd100))
        else $error("hsv result out of range");

    a_grey: assert property (@(posedge clk) disable iff (!rst_n)
        hsv_valid && (hsv.red == hsv.green) && (hsv.green == hsv.blue)
        |-> (hsv.hue == 9'd0) && (hsv.saturation == 7'd0))
        else $error("grey pixel with nonzero hue or saturation");

    a_no_false_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !hsv_valid |-> !pix_stall)
        else $error("input stalled while output slot is empty");
`endif

endmodule
